// ===== design/mimu_pkg.sv =====
// shared types and constants for the mahony imu attitude update block
// no dependencies; used by the divider, square root, multiplier and top level
package mimu_pkg;

   // operand and product widths of the shared multiplier
   localparam int AW   = 38;
   localparam int BW   = 32;
   localparam int PW   = AW + BW;
   localparam int ACCW = 40;

   // iteration counts of the serial units
   localparam int DIV_STEPS = 30;
   localparam int SQ_STEPS  = 32;
   localparam int DIV_MAGW  = 62;

   // register indexes
   localparam logic [1:0] CSR_KI = 2'd0;
   localparam logic [1:0] CSR_KP = 2'd1;
   localparam logic [1:0] CSR_DT = 2'd2;

   localparam logic [15:0] KI_RESET = 16'd819;
   localparam logic [15:0] KP_RESET = 16'd7782;
   localparam logic [24:0] DT_RESET = 25'd16777;

   typedef struct packed {
      logic                start;
      logic                neg;
      logic [DIV_MAGW-1:0] mag;
      logic [31:0]         den;
   } mimu_div_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] val;
   } mimu_sq_req_type;

endpackage

// ===== design/mimu_mul.sv =====
// shared signed multiplier with registered product
// depends on mimu_pkg
module mimu_mul (
   input  logic                            clock,
   input  logic signed [mimu_pkg::AW-1:0]  opa,
   input  logic signed [mimu_pkg::BW-1:0]  opb,
   output logic signed [mimu_pkg::PW-1:0]  prod
);

   logic signed [mimu_pkg::PW-1:0] prod_ff;
   logic signed [mimu_pkg::PW-1:0] prod_in;

   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== design/mimu_div.sv =====
// serial restoring divider, one quotient bit a cycle, result clamped to +-2^30
// depends on mimu_pkg
module mimu_div (
   input  logic                      clock,
   input  logic                      reset,
   input  mimu_pkg::mimu_div_req_type req,
   output logic                      done,
   output logic signed [31:0]        quo
);

   localparam int DS = mimu_pkg::DIV_STEPS;
   localparam int MW = mimu_pkg::DIV_MAGW;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [MW-1:0] dsh_ff, dsh_in;
   logic [DS-1:0] q_ff, q_in;
   logic          neg_ff, neg_in;
   logic          sat_ff, sat_in;
   logic          ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      ge      = rem_ff >= dsh_ff;
      if (req.start) begin
         neg_in = req.neg;
         q_in   = '0;
         cnt_in = '0;
         rem_in = req.mag;
         dsh_in = MW'({req.den, (DS - 1)'(0)});
         if (req.mag >= MW'({req.den, DS'(0)})) begin
            sat_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            sat_in  = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[DS-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
   end

   always_comb begin
      if (sat_ff) begin
         quo = neg_ff ? -32'sd1073741824 : 32'sd1073741824;
      end else begin
         quo = neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
      end
   end

   assign done = done_ff;

endmodule

// ===== design/mimu_sqrt.sv =====
// serial integer floor square root of a 64 bit word, one result bit a cycle
// depends on mimu_pkg
module mimu_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  mimu_pkg::mimu_sq_req_type req,
   output logic                     done,
   output logic [31:0]              root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] b_ff, b_in;
   logic [64:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      trial   = {1'b0, r_ff} + {1'b0, b_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = req.val;
         r_in    = '0;
         b_in    = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in = v_ff - trial[63:0];
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in   = b_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(mimu_pkg::SQ_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

// ===== design/mahony_imu_attitude_update_top.sv =====
// a new word is taken only while idle, once the last word has reached the output register
// the work of a word is set by the one-bit-a-cycle square root and divider
// (up to two square roots and up to seven divisions) and the steps of the shared multiplier
// a finished word waits in the output register while the next word is taken
// reset (synchronous, active high): quaternion (1,0,0,0), integral terms zero,
// gains and sample period to their defaults
module mahony_imu_attitude_update_top (
   input  logic         clock,
   input  logic         reset,
   // configuration write port
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [24:0]  csr_wdata,
   // input words
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
   // result words
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic         rsp_tuser    // accel_applied
);

   localparam int AW   = mimu_pkg::AW;
   localparam int BW   = mimu_pkg::BW;
   localparam int PW   = mimu_pkg::PW;
   localparam int ACCW = mimu_pkg::ACCW;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_SQ1   = 4'd2;
   localparam logic [3:0] S_SQ1W  = 4'd3;
   localparam logic [3:0] S_DV1   = 4'd4;
   localparam logic [3:0] S_DV1W  = 4'd5;
   localparam logic [3:0] S_NCHK  = 4'd6;
   localparam logic [3:0] S_SQ2   = 4'd7;
   localparam logic [3:0] S_SQ2W  = 4'd8;
   localparam logic [3:0] S_DV2   = 4'd9;
   localparam logic [3:0] S_DV2W  = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;

   // multiply program landmarks
   localparam int STEP_SUM  = 2;
   localparam int STEP_CORR = 3;
   localparam int STEP_INT  = 15;
   localparam int STEP_KP   = 21;
   localparam int STEP_H    = 24;
   localparam int STEP_SQ   = 39;
   localparam int STEP_LAST = 42;

   localparam logic signed [ACCW-1:0] ACC_LOW  = 40'sd671088;
   localparam logic signed [ACCW-1:0] ACC_HIGH = 40'sd268435456;
   localparam logic signed [ACCW-1:0] HALF_Q30 = 40'sd536870912;
   localparam logic [63:0]            NORM_MIN = 64'd1152921504606;
   localparam logic signed [47:0]     LIM_I32  = 48'sd2147483647;
   localparam logic signed [47:0]     LIM_Q30  = 48'sd1073741824;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      if (x > 48'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (x < -48'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [47:0] x,
                                                  input logic signed [47:0] lim);
      if (x > lim) begin
         clamp32 = lim[31:0];
      end else if (x < -lim) begin
         clamp32 = -lim[31:0];
      end else begin
         clamp32 = x[31:0];
      end
   endfunction

   // control
   logic [3:0] state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic       phase_ff, phase_in;
   logic [1:0] idx_ff, idx_in;

   // configuration
   logic [15:0] ki_ff, ki_in;
   logic [15:0] kp_ff, kp_in;
   logic [24:0] dt_ff, dt_in;

   // filter state
   logic signed [31:0] q_ff [4];
   logic signed [31:0] q_in [4];
   logic signed [31:0] ifb_ff [3];
   logic signed [31:0] ifb_in [3];

   // working registers of one word
   logic signed [33:0]     g_ff [3];
   logic signed [33:0]     g_in [3];
   logic signed [15:0]     a_ff [3];
   logic signed [15:0]     a_in [3];
   logic signed [32:0]     hv_ff [3];
   logic signed [32:0]     hv_in [3];
   logic signed [31:0]     u_ff [3];
   logic signed [31:0]     u_in [3];
   logic signed [33:0]     he_ff [3];
   logic signed [33:0]     he_in [3];
   logic signed [31:0]     h_ff [3];
   logic signed [31:0]     h_in [3];
   logic signed [31:0]     nq_ff [4];
   logic signed [31:0]     nq_in [4];
   logic signed [36:0]     t_ff, t_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic [31:0]            s_ff, s_in;
   logic [31:0]            r_ff, r_in;
   logic [63:0]            nn_ff, nn_in;
   logic                   applied_ff, applied_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff, rsp_user_in;

   // shared units
   logic signed [AW-1:0] opa;
   logic signed [BW-1:0] opb;
   logic signed [PW-1:0] prod;
   mimu_pkg::mimu_div_req_type div_req;
   mimu_pkg::mimu_sq_req_type  sq_req;
   logic                 div_done, sq_done;
   logic signed [31:0]   div_quo;
   logic [31:0]          sq_root;

   // product views
   logic signed [PW-1:0]   sh30, sh12, sh34, sh22, sh15;
   logic signed [ACCW-1:0] term30, sum_acc, acc_add, acc_sub;
   logic signed [47:0]     isum;
   logic signed [31:0]     ifbn;
   logic [15:0]            abs_a;
   logic [31:0]            abs_nq;

   mimu_mul u_mul (
      .clock (clock),
      .opa   (opa),
      .opb   (opb),
      .prod  (prod)
   );

   mimu_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   mimu_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign sh30    = prod >>> 30;
   assign sh12    = prod >>> 12;
   assign sh34    = prod >>> 34;
   assign sh22    = prod >>> 22;
   assign sh15    = prod >>> 15;
   assign term30  = sh30[ACCW-1:0];
   assign sum_acc = acc_ff + prod[ACCW-1:0];
   assign acc_add = acc_ff + term30;
   assign acc_sub = acc_ff - term30;

   // operand selection of the multiply program
   always_comb begin
      opa = '0;
      opb = '0;
      case (step_ff)
         6'd3:  begin opa = AW'(q_ff[1]);  opb = q_ff[3]; end
         6'd4:  begin opa = AW'(q_ff[0]);  opb = q_ff[2]; end
         6'd5:  begin opa = AW'(q_ff[0]);  opb = q_ff[1]; end
         6'd6:  begin opa = AW'(q_ff[2]);  opb = q_ff[3]; end
         6'd7:  begin opa = AW'(q_ff[0]);  opb = q_ff[0]; end
         6'd8:  begin opa = AW'(q_ff[3]);  opb = q_ff[3]; end
         6'd9:  begin opa = AW'(hv_ff[2]); opb = u_ff[1]; end
         6'd10: begin opa = AW'(hv_ff[1]); opb = u_ff[2]; end
         6'd11: begin opa = AW'(hv_ff[0]); opb = u_ff[2]; end
         6'd12: begin opa = AW'(hv_ff[2]); opb = u_ff[0]; end
         6'd13: begin opa = AW'(hv_ff[1]); opb = u_ff[0]; end
         6'd14: begin opa = AW'(hv_ff[0]); opb = u_ff[1]; end
         6'd27: begin opa = AW'(q_ff[1]);  opb = h_ff[0]; end
         6'd28: begin opa = AW'(q_ff[2]);  opb = h_ff[1]; end
         6'd29: begin opa = AW'(q_ff[3]);  opb = h_ff[2]; end
         6'd30: begin opa = AW'(q_ff[0]);  opb = h_ff[0]; end
         6'd31: begin opa = AW'(q_ff[2]);  opb = h_ff[2]; end
         6'd32: begin opa = AW'(q_ff[3]);  opb = h_ff[1]; end
         6'd33: begin opa = AW'(q_ff[0]);  opb = h_ff[1]; end
         6'd34: begin opa = AW'(q_ff[1]);  opb = h_ff[2]; end
         6'd35: begin opa = AW'(q_ff[3]);  opb = h_ff[0]; end
         6'd36: begin opa = AW'(q_ff[0]);  opb = h_ff[2]; end
         6'd37: begin opa = AW'(q_ff[1]);  opb = h_ff[1]; end
         6'd38: begin opa = AW'(q_ff[2]);  opb = h_ff[0]; end
         default: begin
            for (int i = 0; i < 3; i++) begin
               if (step_ff == 6'(i)) begin
                  opa = AW'(a_ff[i]);
                  opb = BW'(a_ff[i]);
               end
               if (step_ff == 6'(STEP_INT + 2 * i)) begin
                  opa = AW'(he_ff[i]);
                  opb = BW'(ki_ff);
               end
               if (step_ff == 6'(STEP_INT + 2 * i + 1)) begin
                  opa = AW'(t_ff);
                  opb = BW'(dt_ff);
               end
               if (step_ff == 6'(STEP_KP + i)) begin
                  opa = AW'(he_ff[i]);
                  opb = BW'(kp_ff);
               end
               if (step_ff == 6'(STEP_H + i)) begin
                  opa = AW'(g_ff[i]);
                  opb = BW'(dt_ff);
               end
            end
            for (int i = 0; i < 4; i++) begin
               if (step_ff == 6'(STEP_SQ + i)) begin
                  opa = AW'(nq_ff[i]);
                  opb = nq_ff[i];
               end
            end
         end
      endcase
   end

   // serial unit requests
   always_comb begin
      abs_a  = a_ff[idx_ff][15] ? 16'(-a_ff[idx_ff]) : a_ff[idx_ff];
      abs_nq = nq_ff[idx_ff][31] ? 32'(-nq_ff[idx_ff]) : nq_ff[idx_ff];
      div_req.start = (state_ff == S_DV1) || (state_ff == S_DV2);
      div_req.den   = r_ff;
      if (state_ff == S_DV2) begin
         div_req.neg = nq_ff[idx_ff][31];
         div_req.mag = {1'b0, abs_nq[30:0], 30'd0};
      end else begin
         div_req.neg = a_ff[idx_ff][15];
         div_req.mag = {abs_a, 46'd0};
      end
      sq_req.start = (state_ff == S_SQ1) || (state_ff == S_SQ2);
      sq_req.val   = (state_ff == S_SQ2) ? nn_ff : {s_ff, 32'd0};
   end

   assign req_tready = (state_ff == S_IDLE);

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      ki_in        = ki_ff;
      kp_in        = kp_ff;
      dt_in        = dt_ff;
      q_in         = q_ff;
      ifb_in       = ifb_ff;
      g_in         = g_ff;
      a_in         = a_ff;
      hv_in        = hv_ff;
      u_in         = u_ff;
      he_in        = he_ff;
      h_in         = h_ff;
      nq_in        = nq_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      nn_in        = nn_ff;
      applied_in   = applied_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      isum         = '0;
      ifbn         = '0;

      // register writes must come only while idle; the block itself does not enforce this
      if (csr_we) begin
         case (csr_addr)
            mimu_pkg::CSR_KI: ki_in = csr_wdata[15:0];
            mimu_pkg::CSR_KP: kp_in = csr_wdata[15:0];
            mimu_pkg::CSR_DT: dt_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 3; i++) begin
                  g_in[i] = 34'($signed(req_tdata[16 * i +: 16])) <<< 10;
                  a_in[i] = $signed(req_tdata[48 + 16 * i +: 16]);
               end
               applied_in = 1'b0;
               step_in    = '0;
               phase_in   = 1'b0;
               state_in   = S_MUL;
            end
         end

         S_MUL: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               step_in  = step_ff + 6'd1;
               case (step_ff)
                  6'd0: acc_in = prod[ACCW-1:0];
                  6'd1: acc_in = sum_acc;
                  6'd2: begin
                     // acceleration window on the squared magnitude
                     s_in   = sum_acc[31:0];
                     idx_in = '0;
                     if (sum_acc > ACC_LOW && sum_acc < ACC_HIGH) begin
                        applied_in = 1'b1;
                        state_in   = S_SQ1;
                     end else begin
                        step_in = 6'(STEP_H);
                     end
                  end
                  // estimated half gravity
                  6'd3:  acc_in   = term30;
                  6'd4:  hv_in[0] = acc_sub[32:0];
                  6'd5:  acc_in   = term30;
                  6'd6:  hv_in[1] = acc_add[32:0];
                  6'd7:  acc_in   = term30 - HALF_Q30;
                  6'd8:  hv_in[2] = acc_add[32:0];
                  // half error, measured cross estimated
                  6'd9:  acc_in   = term30;
                  6'd10: he_in[0] = acc_sub[33:0];
                  6'd11: acc_in   = term30;
                  6'd12: he_in[1] = acc_sub[33:0];
                  6'd13: acc_in   = term30;
                  6'd14: he_in[2] = acc_sub[33:0];
                  // quaternion rate equation
                  6'd27: acc_in   = ACCW'(q_ff[0]) - term30;
                  6'd28: acc_in   = acc_sub;
                  6'd29: nq_in[0] = clamp32(48'(acc_sub), LIM_I32);
                  6'd30: acc_in   = ACCW'(q_ff[1]) + term30;
                  6'd31: acc_in   = acc_add;
                  6'd32: nq_in[1] = clamp32(48'(acc_sub), LIM_I32);
                  6'd33: acc_in   = ACCW'(q_ff[2]) + term30;
                  6'd34: acc_in   = acc_sub;
                  6'd35: nq_in[2] = clamp32(48'(acc_add), LIM_I32);
                  6'd36: acc_in   = ACCW'(q_ff[3]) + term30;
                  6'd37: acc_in   = acc_add;
                  6'd38: nq_in[3] = clamp32(48'(acc_sub), LIM_I32);
                  default: begin
                     for (int i = 0; i < 3; i++) begin
                        if (step_ff == 6'(STEP_INT + 2 * i)) begin
                           t_in = sh12[36:0];
                        end
                        // integral step; zero gain clears the integral
                        if (step_ff == 6'(STEP_INT + 2 * i + 1)) begin
                           isum = 48'(ifb_ff[i]) + 48'($signed(sh34[32:0]));
                           ifbn = sat32(isum);
                           if (ki_ff == 16'd0) begin
                              ifb_in[i] = '0;
                           end else begin
                              ifb_in[i] = ifbn;
                              g_in[i]   = g_ff[i] + 34'(ifbn);
                           end
                        end
                        if (step_ff == 6'(STEP_KP + i)) begin
                           g_in[i] = g_ff[i] + $signed(sh22[33:0]);
                        end
                        // half angle increment
                        if (step_ff == 6'(STEP_H + i)) begin
                           h_in[i] = sat32($signed(sh15[47:0]));
                        end
                     end
                     for (int i = 0; i < 4; i++) begin
                        if (step_ff == 6'(STEP_SQ + i)) begin
                           nn_in = (i == 0) ? prod[63:0] : nn_ff + prod[63:0];
                        end
                     end
                     if (step_ff == 6'(STEP_LAST)) begin
                        state_in = S_NCHK;
                     end
                  end
               endcase
            end
         end

         S_SQ1: state_in = S_SQ1W;

         S_SQ1W: begin
            if (sq_done) begin
               r_in     = sq_root;
               idx_in   = '0;
               state_in = S_DV1;
            end
         end

         S_DV1: state_in = S_DV1W;

         // unit gravity, one axis per division
         S_DV1W: begin
            if (div_done) begin
               u_in[idx_ff] = div_quo;
               if (idx_ff == 2'd2) begin
                  step_in  = 6'(STEP_CORR);
                  phase_in = 1'b0;
                  state_in = S_MUL;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_DV1;
               end
            end
         end

         S_NCHK: begin
            idx_in = '0;
            if (nn_ff > NORM_MIN) begin
               state_in = S_SQ2;
            end else begin
               // tiny norm: keep unnormalised, clamped
               for (int i = 0; i < 4; i++) begin
                  q_in[i] = clamp32(48'(nq_ff[i]), LIM_Q30);
               end
               state_in = S_FIN;
            end
         end

         S_SQ2: state_in = S_SQ2W;

         S_SQ2W: begin
            if (sq_done) begin
               r_in     = sq_root;
               state_in = S_DV2;
            end
         end

         S_DV2: state_in = S_DV2W;

         S_DV2W: begin
            if (div_done) begin
               q_in[idx_ff] = div_quo;
               if (idx_ff == 2'd3) begin
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_DV2;
               end
            end
         end

         // hand over once the output register is free
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {q_ff[3], q_ff[2], q_ff[1], q_ff[0]};
               rsp_user_in  = applied_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         phase_ff     <= 1'b0;
         idx_ff       <= '0;
         ki_ff        <= mimu_pkg::KI_RESET;
         kp_ff        <= mimu_pkg::KP_RESET;
         dt_ff        <= mimu_pkg::DT_RESET;
         q_ff[0]      <= 32'sd1073741824;
         q_ff[1]      <= '0;
         q_ff[2]      <= '0;
         q_ff[3]      <= '0;
         ifb_ff[0]    <= '0;
         ifb_ff[1]    <= '0;
         ifb_ff[2]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         ki_ff        <= ki_in;
         kp_ff        <= kp_in;
         dt_ff        <= dt_in;
         q_ff         <= q_in;
         ifb_ff       <= ifb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      g_ff        <= g_in;
      a_ff        <= a_in;
      hv_ff       <= hv_in;
      u_ff        <= u_in;
      he_ff       <= he_in;
      h_ff        <= h_in;
      nq_ff       <= nq_in;
      t_ff        <= t_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      r_ff        <= r_in;
      nn_ff       <= nn_in;
      applied_ff  <= applied_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== test/mahony_imu_attitude_update_top_tb.sv =====
// self-checking bench for the mahony imu attitude update block
// drives sample words, predicts each quaternion update in fixed point and compares
// depends on mimu_pkg and mahony_imu_attitude_update_top
module mahony_imu_attitude_update_top_tb;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [24:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;   // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;       // quat_w, quat_x, quat_y, quat_z
   logic         rsp_tuser;       // accel_applied

   typedef struct packed {
      logic [127:0] quat;
      logic         applied;
   } attitude_word_type;

   typedef struct {
      logic [95:0]  sample;
      logic         known;      // expected result typed in
      logic [127:0] quat;
      logic         applied;
   } sample_row_type;

   // predictor copy of the block state and registers
   longint att_q[4];
   longint int_fb[3];
   longint ki_reg, kp_reg, dt_reg;

   attitude_word_type expected_words[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  stim_done = 1'b0;
   localparam int WATCHDOG = 40000;
   localparam longint ONE_Q30 = 64'sd1 << 30;

   mahony_imu_attitude_update_top uut (.*);

   // 12 unit clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint asr_n(longint x, int n);
      return x >>> n;
   endfunction

   function automatic longint clamp_to(longint x, longint lim);
      return x > lim ? lim : (x < -lim ? -lim : x);
   endfunction

   function automatic longint sat_32(longint x);
      return x > 64'sd2147483647 ? 64'sd2147483647 :
             (x < -64'sd2147483648 ? -64'sd2147483648 : x);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint div_trunc(longint num, longint unsigned den);
      longint unsigned mag, qv;
      mag = num < 0 ? 64'd0 - longint'(num) : num;
      qv = mag / den;
      return num < 0 ? -longint'(qv) : longint'(qv);
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   // one filter step on the predictor state
   function automatic attitude_word_type update_attitude(logic [95:0] sample);
      longint g[3], a[3], h[3], nq[4], u[3], hv[3], he[3];
      longint s, t;
      longint unsigned den, nn, r;
      attitude_word_type w;
      logic app;
      for (int i = 0; i < 3; i++) begin
         g[i] = longint'($signed(sample[16*i +: 16])) * 1024;
         a[i] = longint'($signed(sample[16*(i+3) +: 16]));
      end
      s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      app = (s > 671088) && (s < (64'sd1 << 28));
      if (app) begin
         den = floor_sqrt(longint'(s) << 32);
         for (int i = 0; i < 3; i++)
            u[i] = clamp_to(div_trunc(a[i] * (64'sd1 << 46), den), ONE_Q30);
         hv[0] = mul_q30(att_q[1], att_q[3]) - mul_q30(att_q[0], att_q[2]);
         hv[1] = mul_q30(att_q[0], att_q[1]) + mul_q30(att_q[2], att_q[3]);
         hv[2] = mul_q30(att_q[0], att_q[0]) - (ONE_Q30 >>> 1)
                 + mul_q30(att_q[3], att_q[3]);
         he[0] = mul_q30(u[1], hv[2]) - mul_q30(u[2], hv[1]);
         he[1] = mul_q30(u[2], hv[0]) - mul_q30(u[0], hv[2]);
         he[2] = mul_q30(u[0], hv[1]) - mul_q30(u[1], hv[0]);
         for (int i = 0; i < 3; i++) begin
            if (ki_reg != 0) begin
               t = asr_n(ki_reg * he[i], 12);
               int_fb[i] = sat_32(int_fb[i] + asr_n(t * dt_reg, 34));
               g[i] += int_fb[i];
            end else begin
               int_fb[i] = 0;
            end
            g[i] += asr_n(kp_reg * he[i], 22);
         end
      end
      for (int i = 0; i < 3; i++) h[i] = sat_32(asr_n(g[i] * dt_reg, 15));
      nq[0] = att_q[0] - mul_q30(att_q[1], h[0]) - mul_q30(att_q[2], h[1])
              - mul_q30(att_q[3], h[2]);
      nq[1] = att_q[1] + mul_q30(att_q[0], h[0]) + mul_q30(att_q[2], h[2])
              - mul_q30(att_q[3], h[1]);
      nq[2] = att_q[2] + mul_q30(att_q[0], h[1]) - mul_q30(att_q[1], h[2])
              + mul_q30(att_q[3], h[0]);
      nq[3] = att_q[3] + mul_q30(att_q[0], h[2]) + mul_q30(att_q[1], h[1])
              - mul_q30(att_q[2], h[0]);
      nn = 0;
      for (int i = 0; i < 4; i++) begin
         nq[i] = clamp_to(nq[i], 64'sd2147483647);
         nn += longint'(nq[i] * nq[i]);
      end
      if (nn > 64'd1152921504606) begin
         r = floor_sqrt(nn);
         for (int i = 0; i < 4; i++) nq[i] = div_trunc(nq[i] * ONE_Q30, r);
      end
      for (int i = 0; i < 4; i++) begin
         att_q[i] = clamp_to(nq[i], ONE_Q30);
         w.quat[32*i +: 32] = att_q[i][31:0];
      end
      w.applied = app;
      return w;
   endfunction

   function automatic logic [95:0] pack_sample(int gx, int gy, int gz,
                                               int ax, int ay, int az);
      logic [15:0] f[6];
      f = '{gx[15:0], gy[15:0], gz[15:0], ax[15:0], ay[15:0], az[15:0]};
      return {f[5], f[4], f[3], f[2], f[1], f[0]};
   endfunction

   function automatic int gap_len();
      // mostly short, now and then long, often none
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 400);
   endfunction

   task automatic write_csr(logic [1:0] idx, longint value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[24:0];
      case (idx)
         mimu_pkg::CSR_KI: ki_reg = value & 16'hFFFF;
         mimu_pkg::CSR_KP: kp_reg = value & 16'hFFFF;
         mimu_pkg::CSR_DT: dt_reg = value & 25'h1FFFFFF;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // one sample word through the input handshake
   task automatic send_sample(logic [95:0] sample, logic chk, attitude_word_type typed);
      attitude_word_type w;
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      w = update_attitude(sample);
      if (chk && w !== typed)
         $display("%0t: table row disagrees with predictor exp %h act %h", $time, typed, w);
      expected_words.push_back(chk ? typed : w);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);   // full latency with correction, plus margin
   endtask

   // result side: random stalls, compare with the oldest expectation
   initial begin
      attitude_word_type exp_w;
      int stall;
      @(negedge reset);
      forever begin
         stall = gap_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word act %h/%b", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            for (int i = 0; i < 4; i++)
               if (rsp_tdata[32*i +: 32] !== exp_w.quat[32*i +: 32]) begin
                  $display("%0t: quat[%0d] exp %h act %h", $time, i,
                           exp_w.quat[32*i +: 32], rsp_tdata[32*i +: 32]);
                  errors++;
               end
            if (rsp_tuser !== exp_w.applied) begin
               $display("%0t: accel_applied exp %b act %b", $time, exp_w.applied,
                        rsp_tuser);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG && !stim_done) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      sample_row_type rows[$];
      sample_row_type row;
      attitude_word_type none;
      int level, ax, ay, az;
      none = '0;
      att_q = '{ONE_Q30, 0, 0, 0};
      int_fb = '{0, 0, 0};
      ki_reg = mimu_pkg::KI_RESET;
      kp_reg = mimu_pkg::KP_RESET;
      dt_reg = mimu_pkg::DT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table: typed expectations only where obvious
      // still sample after reset leaves the quaternion at one
      row = '{pack_sample(0, 0, 0, 0, 0, 0), 1'b1, {96'd0, 32'sd1 << 30}, 1'b0};
      rows.push_back(row);
      // level with 1 g on z: gravity agrees, no error, correction runs
      row = '{pack_sample(0, 0, 0, 0, 0, 8192), 1'b1, {96'd0, 32'sd1 << 30}, 1'b1};
      rows.push_back(row);
      // acceleration at and around the window edges
      rows.push_back('{pack_sample(0, 0, 0, 0, 0, 819), 0, 0, 0});
      rows.push_back('{pack_sample(0, 0, 0, 0, 0, 820), 0, 0, 0});
      rows.push_back('{pack_sample(0, 0, 0, 0, 0, 16383), 0, 0, 0});
      rows.push_back('{pack_sample(0, 0, 0, 16384, 0, 0), 0, 0, 0});
      rows.push_back('{pack_sample(0, 0, 0, -32768, -32768, -32768), 0, 0, 0});
      // gyro extremes, tilted gravity
      rows.push_back('{pack_sample(32767, -32768, 32767, 5000, -3000, 6000), 0, 0, 0});
      rows.push_back('{pack_sample(-32768, 32767, -32768, -8192, 0, 0), 0, 0, 0});
      rows.push_back('{pack_sample(-1, -1, -1, 0, 8192, 0), 0, 0, 0});
      rows.push_back('{pack_sample(32767, 32767, 32767, 32767, 0, 0), 0, 0, 0});
      rows.push_back('{pack_sample(1, 0, -1, 0, 0, -8192), 0, 0, 0});
      foreach (rows[i]) send_sample(rows[i].sample, rows[i].known,
                                    '{rows[i].quat, rows[i].applied});
      drain();

      // register phases: zero integral gain, extremes of each register
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_csr(mimu_pkg::CSR_KI, 0); write_csr(mimu_pkg::CSR_KP, 65535);
                     write_csr(mimu_pkg::CSR_DT, 1); end
            1: begin write_csr(mimu_pkg::CSR_KI, 65535); write_csr(mimu_pkg::CSR_KP, 0);
                     write_csr(mimu_pkg::CSR_DT, 25'd16777216); end
            2: begin write_csr(mimu_pkg::CSR_KI, 0); write_csr(mimu_pkg::CSR_KP, 7782);
                     write_csr(mimu_pkg::CSR_DT, 0); end
            3: begin write_csr(mimu_pkg::CSR_KI, $urandom_range(0, 65535));
                     write_csr(mimu_pkg::CSR_KP, $urandom_range(0, 65535));
                     write_csr(mimu_pkg::CSR_DT, $urandom_range(1, 1 << 20)); end
            4: begin write_csr(mimu_pkg::CSR_KI, 65535);
                     write_csr(mimu_pkg::CSR_KP, 65535);
                     write_csr(mimu_pkg::CSR_DT, 100000); end
            default: begin write_csr(mimu_pkg::CSR_KI, mimu_pkg::KI_RESET);
                     write_csr(mimu_pkg::CSR_KP, mimu_pkg::KP_RESET);
                     write_csr(mimu_pkg::CSR_DT, mimu_pkg::DT_RESET); end
         endcase
         for (int n = 0; n < 265; n++) begin
            level = $urandom_range(0, 9);
            if (level < 7) begin
               // plausible gravity near 1 g, most samples corrected
               ax = $urandom_range(0, 12000) - 6000;
               ay = $urandom_range(0, 12000) - 6000;
               az = $urandom_range(0, 16000) - 8000;
               send_sample(pack_sample($urandom_range(0, 4000) - 2000,
                                       $urandom_range(0, 4000) - 2000,
                                       $urandom_range(0, 4000) - 2000, ax, ay, az),
                           1'b0, none);
            end else begin
               send_sample($urandom() ^ {$urandom(), $urandom(), $urandom()}, 1'b0, none);
            end
         end
         drain();
      end

      stim_done = 1'b1;
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
